FILE: rtl/ihp_pkg.sv
`default_nettype none

package ihp_pkg;

	localparam int WORD_W     = 32;
	localparam int POS_W      = 28;
	localparam int SAT_W      = 9;
	localparam int TGT_W      = 10;
	localparam int OFF_W      = 10;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;
	localparam int OUT_DATA_W = 200;

	localparam logic [WORD_W-1:0] SFCI_MAGIC   = 32'h4943_4653;
	localparam logic [15:0]       TYPE_CLOSE   = 16'd2;
	localparam logic [15:0]       TYPE_REQUEST = 16'd4;
	localparam logic [7:0]        DOM_CMD_CLOSE = 8'd2;

	// Register index, taken from paddr[2].
	localparam logic REG_DOMAIN_SESSION = 1'b0;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              last;
	} in_item_t;

	typedef struct packed {
		logic [15:0]       msg_type;
		logic [11:0]       desc_counts;
		logic [3:0]        copy_count;
		logic [5:0]        move_count;
		logic              has_pid;
		logic [63:0]       pid;
		logic [OFF_W-1:0]  raw_offset;
		logic [OFF_W-1:0]  sfci_offset;
		logic [31:0]       domain_handle;
		logic [7:0]        domain_command;
		logic [31:0]       cmd_id;
		logic              header_ok;
	} result_t;

	// Saturates at word 511; byte_off maps every position from word 256 up to one offset.
	function automatic logic [SAT_W-1:0] pos_sat(input logic [POS_W-1:0] v);
		pos_sat = (|v[POS_W-1:SAT_W]) ? {SAT_W{1'b1}} : v[SAT_W-1:0];
	endfunction

	function automatic logic [OFF_W-1:0] byte_off(input logic [SAT_W-1:0] v);
		byte_off = v[SAT_W-1] ? {OFF_W{1'b1}} : {v[SAT_W-2:0], 2'b00};
	endfunction

endpackage

`default_nettype wire

FILE: rtl/ihp_in_reg.sv
`default_nettype none

module ihp_in_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ihp_pkg::in_item_t in_item,
	input  logic             advance,
	output logic             s1_valid,
	output ihp_pkg::in_item_t s1_item
);
	import ihp_pkg::*;

	logic     valid_s1;
	in_item_t item_s1;

	assign in_ready = !valid_s1 || advance;
	assign s1_valid = valid_s1;
	assign s1_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/ihp_parse.sv
`default_nettype none

module ihp_parse #(
	parameter int MSG_WORDS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  ihp_pkg::in_item_t item,
	input  logic              domain_session,
	output logic              res_valid,
	output ihp_pkg::result_t  res
);
	import ihp_pkg::*;

	localparam int IDX_W = $clog2(MSG_WORDS);

	typedef enum logic [3:0] {
		PH_HDR0, PH_HDR1, PH_HD, PH_PIDLO, PH_PIDHI,
		PH_DOM0, PH_DOM1, PH_MAGIC, PH_CMD, PH_DONE
	} phase_t;

	phase_t             phase_q, phase_n;
	logic [IDX_W-1:0]   idx_q;
	logic [TGT_W-1:0]   tgt_q, tgt_n;
	logic               given_q, dom_used_q, dom_used_n, magic_q, magic_n;
	logic [27:0]        hdr_q, hdr_n;
	logic [WORD_W-1:0]  hd_q, hd_n;
	logic [63:0]        pid_q, pid_n;
	logic [7:0]         dcmd_q, dcmd_n;
	logic [31:0]        dhandle_q, dhandle_n;
	logic [SAT_W-1:0]   raw_q, raw_n, sfci_q, sfci_n;

	logic [WORD_W-1:0]  w;
	logic               match, at_end, cmd_emit, ok;
	logic [WORD_W-1:0]  plan_hd;
	logic [2:0]         plan_base;
	logic [3:0]         cnt_x, cnt_a, cnt_b;
	logic [POS_W-1:0]   raw_full, aligned_full, aligned, sfci_full;
	logic               dom_plan;

	assign w      = item.word;
	assign match  = (phase_q != PH_DONE) && (TGT_W'(idx_q) == tgt_q);
	assign at_end = item.last || (idx_q == IDX_W'(MSG_WORDS - 1));

	// Layout of the descriptor area, shared by the three phases that can end the header.
	assign plan_hd = (phase_q == PH_HD) ? w : hd_q;
	assign cnt_x   = hdr_q[19:16];
	assign cnt_a   = hdr_q[23:20];
	assign cnt_b   = hdr_q[27:24];

	always_comb begin
		priority if (phase_q == PH_HDR1) begin
			plan_base = 3'd2;
		end else if (phase_q == PH_HD) begin
			plan_base = 3'd3;
		end else begin
			plan_base = 3'd5;
		end
	end

	assign raw_full = POS_W'(plan_base) + POS_W'(plan_hd[4:1]) + POS_W'(plan_hd[31:5])
		+ POS_W'({cnt_x, 1'b0}) + POS_W'(cnt_a) + POS_W'({cnt_a, 1'b0})
		+ POS_W'(cnt_b) + POS_W'({cnt_b, 1'b0});
	assign aligned_full = raw_full + POS_W'(3);
	assign aligned      = {aligned_full[POS_W-1:2], 2'b00};
	assign dom_plan     = domain_session && (hdr_q[15:0] == TYPE_REQUEST);
	assign sfci_full    = aligned + (dom_plan ? POS_W'(4) : POS_W'(0));

	always_comb begin
		phase_n    = phase_q;
		tgt_n      = tgt_q;
		dom_used_n = dom_used_q;
		magic_n    = magic_q;
		hdr_n      = hdr_q;
		hd_n       = hd_q;
		pid_n      = pid_q;
		dcmd_n     = dcmd_q;
		dhandle_n  = dhandle_q;
		raw_n      = raw_q;
		sfci_n     = sfci_q;
		cmd_emit   = 1'b0;
		ok         = 1'b0;
		if (match) begin
			unique case (phase_q)
				PH_HDR0: begin
					hdr_n   = w[27:0];
					phase_n = PH_HDR1;
					tgt_n   = TGT_W'(1);
				end
				PH_HDR1, PH_HD, PH_PIDHI: begin
					if (phase_q == PH_HDR1 && w[31]) begin
						phase_n = PH_HD;
						tgt_n   = TGT_W'(2);
					end else if (phase_q == PH_HD && w[0]) begin
						hd_n    = w;
						phase_n = PH_PIDLO;
						tgt_n   = TGT_W'(3);
					end else begin
						if (phase_q == PH_HD) begin
							hd_n = w;
						end
						if (phase_q == PH_PIDHI) begin
							pid_n[63:32] = w;
						end
						raw_n      = pos_sat(raw_full);
						sfci_n     = pos_sat(sfci_full);
						tgt_n      = TGT_W'(pos_sat(aligned));
						dom_used_n = dom_plan;
						phase_n    = dom_plan ? PH_DOM0 : PH_MAGIC;
					end
				end
				PH_PIDLO: begin
					pid_n   = {32'd0, w};
					phase_n = PH_PIDHI;
					tgt_n   = TGT_W'(4);
				end
				PH_DOM0: begin
					dcmd_n  = w[7:0];
					phase_n = PH_DOM1;
					tgt_n   = tgt_q + TGT_W'(1);
				end
				PH_DOM1: begin
					dhandle_n = w;
					phase_n   = PH_MAGIC;
					tgt_n     = TGT_W'(sfci_q);
				end
				PH_MAGIC: begin
					magic_n = (w == SFCI_MAGIC);
					phase_n = PH_CMD;
					tgt_n   = TGT_W'(sfci_q) + TGT_W'(2);
				end
				PH_CMD: begin
					cmd_emit = 1'b1;
					ok       = magic_q || (hdr_q[15:0] == TYPE_CLOSE)
						|| (dom_used_q && (dcmd_q == DOM_CMD_CLOSE));
					phase_n  = PH_DONE;
				end
				PH_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	assign res_valid = cmd_emit || (at_end && !given_q);

	always_comb begin
		res.msg_type       = hdr_n[15:0];
		res.desc_counts    = hdr_n[27:16];
		res.copy_count     = hd_n[4:1];
		res.move_count     = (|hd_n[31:11]) ? 6'd63 : hd_n[10:5];
		res.has_pid        = hd_n[0];
		res.pid            = pid_n;
		res.raw_offset     = byte_off(raw_n);
		res.sfci_offset    = byte_off(sfci_n);
		res.domain_handle  = dhandle_n;
		res.domain_command = dcmd_n;
		res.cmd_id         = cmd_emit ? w : 32'd0;
		res.header_ok      = ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR0;
			idx_q      <= '0;
			tgt_q      <= '0;
			given_q    <= 1'b0;
			dom_used_q <= 1'b0;
			magic_q    <= 1'b0;
			hdr_q      <= '0;
			hd_q       <= '0;
			pid_q      <= '0;
			dcmd_q     <= '0;
			dhandle_q  <= '0;
			raw_q      <= '0;
			sfci_q     <= '0;
		end else if (step) begin
			if (at_end) begin
				phase_q    <= PH_HDR0;
				idx_q      <= '0;
				tgt_q      <= '0;
				given_q    <= 1'b0;
				dom_used_q <= 1'b0;
				magic_q    <= 1'b0;
				hdr_q      <= '0;
				hd_q       <= '0;
				pid_q      <= '0;
				dcmd_q     <= '0;
				dhandle_q  <= '0;
				raw_q      <= '0;
				sfci_q     <= '0;
			end else begin
				phase_q    <= phase_n;
				idx_q      <= idx_q + IDX_W'(1);
				tgt_q      <= tgt_n;
				given_q    <= given_q || cmd_emit;
				dom_used_q <= dom_used_n;
				magic_q    <= magic_n;
				hdr_q      <= hdr_n;
				hd_q       <= hd_n;
				pid_q      <= pid_n;
				dcmd_q     <= dcmd_n;
				dhandle_q  <= dhandle_n;
				raw_q      <= raw_n;
				sfci_q     <= sfci_n;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/ihp_out_reg.sv
`default_nettype none

module ihp_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  ihp_pkg::result_t load_data,
	output logic             free,
	output logic             out_valid,
	input  logic             out_ready,
	output ihp_pkg::result_t out_data
);
	import ihp_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= load_data;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/ipc_request_header_parser_unit.sv
`default_nettype none

// Channel   | Direction | Signals                              | Carries
// ----------+-----------+--------------------------------------+--------------------------------
// s_*       | in        | s_tvalid s_tready s_tdata s_tlast    | one message word per request
// m_*       | out       | m_tvalid m_tready m_tdata m_tuser    | one parse result per message
// apb       | in/out    | psel penable pwrite paddr pwdata ... | domain_session register at 0x0
//
// A word is parsed straight out of the input register once the output register is free; a
// result is loaded into the output register as its last relevant word is parsed.
// A new word is taken every cycle while the output register is empty or being drained.
// A stalled output register holds the word in the input register and drops s_tready.
// Reset clears the parse state, both valid flags and domain_session; no clearing pass.

module ipc_request_header_parser_unit #(
	parameter int MSG_WORDS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [31:0]                      s_tdata,  // msg_word
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// msg_type, desc_counts, copy_count, move_count, has_pid, pid, raw_offset,
	// sfci_offset, domain_handle, domain_command, cmd_id, zero fill
	output logic [ihp_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                             m_tuser,  // header_ok
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ihp_pkg::PADDR_W-1:0]      paddr,
	input  logic [ihp_pkg::PDATA_W-1:0]      pwdata,
	output logic [ihp_pkg::PDATA_W-1:0]      prdata,
	output logic                             pready
);
	import ihp_pkg::*;

	logic     domain_session_q;
	logic     s1_valid, advance, out_free, res_valid;
	in_item_t in_item, s1_item;
	result_t  res, out_res;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DOMAIN_SESSION) ? PDATA_W'(domain_session_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			domain_session_q <= 1'b0;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == REG_DOMAIN_SESSION) begin
			domain_session_q <= pwdata[0];
		end
	end

	assign in_item.word = s_tdata;
	assign in_item.last = s_tlast;
	assign advance      = s1_valid && out_free;

	ihp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (advance),
		.s1_valid (s1_valid),
		.s1_item  (s1_item)
	);

	ihp_parse #(
		.MSG_WORDS (MSG_WORDS)
	) u_parse (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.item           (s1_item),
		.domain_session (domain_session_q),
		.res_valid      (res_valid),
		.res            (res)
	);

	ihp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.load_data (res),
		.free      (out_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {5'd0, out_res.cmd_id, out_res.domain_command, out_res.domain_handle,
		out_res.sfci_offset, out_res.raw_offset, out_res.pid, out_res.has_pid,
		out_res.move_count, out_res.copy_count, out_res.desc_counts, out_res.msg_type};
	assign m_tuser = out_res.header_ok;

endmodule

`default_nettype wire

FILE: rtl/ihp_checker.sv
`default_nettype none

module ihp_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [199:0] m_tdata,
	input logic         m_tuser
);

	// A stalled result must hold.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// The output register drains in the same cycle, so the input side must be open.
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output is ready");

	// The magic word never lies before the raw data area.
	a_offset_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[112:103] <= m_tdata[122:113])
		else $error("sfci offset below raw offset");

	// A process id is only captured when the handle descriptor asks for one.
	a_pid_gated: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[38] |-> m_tdata[102:39] == 64'd0)
		else $error("process id without pid flag");

endmodule

bind ipc_request_header_parser_unit ihp_checker u_ihp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
